// File: rtl/shbi_pkg.sv
`default_nettype none

package shbi_pkg;

   // Number of remix retries after the hash, when the value falls in the biased tail
   localparam int MAX_RETRIES = 4;

   // Mixing constants
   localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
   localparam logic [31:0] MIX_MUL1  = 32'h85EBCA6B;
   localparam logic [31:0] MIX_MUL2  = 32'hC2B2AE35;
   localparam logic [31:0] SALT_BASE = 32'hA5A5A5A5;
   localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;

   // Remainder pipeline: quotient bits resolved per stage and stage count
   localparam int DVD_W       = 32;
   localparam int REM_STEP    = 4;
   localparam int DIV_STAGES  = DVD_W / REM_STEP;

   // Request register, limit remainder, three hash rounds, retries, index remainder, output;
   // each mix round is two register stages
   localparam int LATENCY = 2 + 2 * DIV_STAGES + 2 * (3 + MAX_RETRIES);

   typedef struct packed {
      logic [7:0]  category;
      logic [31:0] input_id;
      logic [15:0] location_key;
      logic [15:0] bound;
   } req_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [15:0] index;
   } rsp_type;

   // Everything that travels with an item down the pipeline
   typedef struct packed {
      logic [15:0] bound;
      logic [31:0] input_id;
      logic [15:0] location_key;
      logic [31:0] limit;
      logic [31:0] hash;
      logic [31:0] val;
      logic        skip;
   } ctx_type;

   // Value XORed in before retry number r (from 1)
   function automatic logic [31:0] retry_key(input int unsigned r);
      logic [31:0] rr;
      rr = 32'(r);
      return GOLDEN * rr;
   endfunction

endpackage

`default_nettype wire

// File: rtl/shbi_mix.sv
`default_nettype none

module shbi_mix (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire shbi_pkg::ctx_type in_ctx,
   input  wire logic [31:0]      in_pre,
   output logic                  out_valid,
   output shbi_pkg::ctx_type     out_ctx
);

   logic [1:0]        vld_ff;
   shbi_pkg::ctx_type ctx_a_ff;
   shbi_pkg::ctx_type ctx_b_ff;
   logic [31:0]       mul_a_ff;
   logic [31:0]       mul_a_in;
   logic [31:0]       mul_b_ff;
   logic [31:0]       mul_b_in;
   logic [31:0]       mixed;

   // First half: XOR in the pre value, add golden ratio, fold high half, first multiply
   always_comb begin
      logic [31:0] x;
      x = (in_ctx.val ^ in_pre) + shbi_pkg::GOLDEN;
      x = x ^ (x >> 16);
      mul_a_in = x * shbi_pkg::MIX_MUL1;
   end

   // Second half: fold by 13, second multiply
   always_comb begin
      logic [31:0] y;
      y = mul_a_ff ^ (mul_a_ff >> 13);
      mul_b_in = y * shbi_pkg::MIX_MUL2;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      ctx_a_ff <= in_ctx;
      mul_b_ff <= mul_b_in;
      ctx_b_ff <= ctx_a_ff;
   end

   // Final fold; a skipped item keeps its incoming value
   always_comb begin
      mixed   = mul_b_ff ^ (mul_b_ff >> 16);
      out_ctx = ctx_b_ff;
      if (!ctx_b_ff.skip) begin
         out_ctx.val = mixed;
      end
   end

   assign out_valid = vld_ff[1];

endmodule

`default_nettype wire

// File: rtl/shbi_rem.sv
`default_nettype none

module shbi_rem (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire shbi_pkg::ctx_type in_ctx,
   input  wire logic [31:0]       in_dividend,
   output logic                   out_valid,
   output shbi_pkg::ctx_type      out_ctx,
   output logic [15:0]            out_rem
);

   localparam int NS = shbi_pkg::DIV_STAGES;

   logic              vld_ff [NS];
   logic [15:0]       rem_ff [NS];
   logic [31:0]       dvd_ff [NS];
   shbi_pkg::ctx_type ctx_ff [NS];

   genvar g;
   for (g = 0; g < NS; g++) begin : g_stage
      logic              src_vld;
      logic [15:0]       src_rem;
      logic [31:0]       src_dvd;
      shbi_pkg::ctx_type src_ctx;
      logic [15:0]       rem_in;
      logic [31:0]       dvd_in;

      // Select the stage source: port for the first, previous stage otherwise
      if (g == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = '0;
         assign src_dvd = in_dividend;
         assign src_ctx = in_ctx;
      end else begin : g_next
         assign src_vld = vld_ff[g-1];
         assign src_rem = rem_ff[g-1];
         assign src_dvd = dvd_ff[g-1];
         assign src_ctx = ctx_ff[g-1];
      end

      // Shift in dividend bits, restoring subtract per bit
      always_comb begin
         logic [15:0] r;
         logic [31:0] d;
         logic [16:0] t;
         r = src_rem;
         d = src_dvd;
         for (int k = 0; k < shbi_pkg::REM_STEP; k++) begin
            t = {r, d[31]};
            d = {d[30:0], 1'b0};
            if (t >= {1'b0, src_ctx.bound}) begin
               t = t - {1'b0, src_ctx.bound};
            end
            r = t[15:0];
         end
         rem_in = r;
         dvd_in = d;
      end

      // Advance valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= src_vld;
         end
      end

      // Advance payload
      always_ff @(posedge clock) begin
         rem_ff[g] <= rem_in;
         dvd_ff[g] <= dvd_in;
         ctx_ff[g] <= src_ctx;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_ctx   = ctx_ff[NS-1];
   assign out_rem   = rem_ff[NS-1];

endmodule

`default_nettype wire

// File: rtl/seeded_hash_bounded_index.sv
`default_nettype none

// Channel   Ports                                  Direction  Transfer when
// request   start, busy, req_data                  in         start && !busy
// result    rsp_strobe, rsp_data                   out        rsp_strobe (one cycle)
// seed      csr_valid, csr_ready, csr_wdata        in         csr_valid && csr_ready
//
// One request enters per cycle; each result passes one request register, two
// 8-stage remainder pipelines (4 quotient bits per stage), 2 stages per mix
// round for three hash rounds plus the retry rounds, and the output register.
// Busy and csr_ready stay constant.
// Synchronous reset clears the seed and all valid bits; no clearing pass.
// The result side has no backpressure, so the pipeline never stalls.

module seeded_hash_bounded_index (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire shbi_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output shbi_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [31:0]       csr_wdata
);

   localparam int NR = shbi_pkg::MAX_RETRIES;

   logic [31:0]       seed_ff;
   logic              s1_vld_ff;
   shbi_pkg::ctx_type s1_ctx_ff;
   shbi_pkg::ctx_type s1_ctx_in;

   logic              lim_vld;
   shbi_pkg::ctx_type lim_ctx_raw;
   logic [15:0]       lim_rem;
   shbi_pkg::ctx_type lim_ctx;

   logic              m1_vld;
   shbi_pkg::ctx_type m1_ctx;
   logic              m2_vld;
   shbi_pkg::ctx_type m2_ctx;
   logic              m3_vld;
   shbi_pkg::ctx_type m3_ctx;

   logic              rt_vld [NR+1];
   shbi_pkg::ctx_type rt_ctx [NR+1];

   logic              ix_vld;
   shbi_pkg::ctx_type ix_ctx;
   logic [15:0]       ix_rem;

   logic              rsp_strobe_ff;
   shbi_pkg::rsp_type rsp_data_ff;
   shbi_pkg::rsp_type rsp_data_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Hold the seed; written only on a seed transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         seed_ff <= csr_wdata;
      end
   end

   // Salt the seed by category and load the request
   always_comb begin
      logic [31:0] cat_p1;
      cat_p1                 = 32'(req_data.category) + 32'd1;
      s1_ctx_in              = '0;
      s1_ctx_in.bound        = req_data.bound;
      s1_ctx_in.input_id     = req_data.input_id;
      s1_ctx_in.location_key = req_data.location_key;
      s1_ctx_in.val          = seed_ff ^ (shbi_pkg::SALT_BASE * cat_p1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctx_ff <= s1_ctx_in;
   end

   // Rejection limit: largest multiple of bound, from all-ones modulo bound
   shbi_rem u_lim_rem (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_vld_ff),
      .in_ctx      (s1_ctx_ff),
      .in_dividend (shbi_pkg::ALL_ONES),
      .out_valid   (lim_vld),
      .out_ctx     (lim_ctx_raw),
      .out_rem     (lim_rem)
   );

   always_comb begin
      lim_ctx       = lim_ctx_raw;
      lim_ctx.limit = shbi_pkg::ALL_ONES - {16'd0, lim_rem};
   end

   // Three hash rounds; id and duplicated key enter ahead of rounds two and three
   shbi_mix u_mix1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lim_vld),
      .in_ctx    (lim_ctx),
      .in_pre    ('0),
      .out_valid (m1_vld),
      .out_ctx   (m1_ctx)
   );

   shbi_mix u_mix2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_vld),
      .in_ctx    (m1_ctx),
      .in_pre    (m1_ctx.input_id),
      .out_valid (m2_vld),
      .out_ctx   (m2_ctx)
   );

   shbi_mix u_mix3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_vld),
      .in_ctx    (m2_ctx),
      .in_pre    ({m2_ctx.location_key, m2_ctx.location_key}),
      .out_valid (m3_vld),
      .out_ctx   (m3_ctx)
   );

   // Capture the hash ahead of the retries
   always_comb begin
      rt_ctx[0]      = m3_ctx;
      rt_ctx[0].hash = m3_ctx.val;
   end
   assign rt_vld[0] = m3_vld;

   // Retry rounds: remix only while the value sits at or above the limit and bound is two or more
   genvar g;
   for (g = 0; g < NR; g++) begin : g_retry
      shbi_pkg::ctx_type rt_in;

      always_comb begin
         rt_in      = rt_ctx[g];
         rt_in.skip = (rt_ctx[g].bound < 16'd2) || (rt_ctx[g].val < rt_ctx[g].limit);
      end

      shbi_mix u_mix_rt (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rt_vld[g]),
         .in_ctx    (rt_in),
         .in_pre    (shbi_pkg::retry_key(g + 1)),
         .out_valid (rt_vld[g+1]),
         .out_ctx   (rt_ctx[g+1])
      );
   end

   // Reduce the final value modulo bound
   shbi_rem u_idx_rem (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rt_vld[NR]),
      .in_ctx      (rt_ctx[NR]),
      .in_dividend (rt_ctx[NR].val),
      .out_valid   (ix_vld),
      .out_ctx     (ix_ctx),
      .out_rem     (ix_rem)
   );

   // Drop the remainder when bound is zero or one
   always_comb begin
      rsp_data_in.hash_value = ix_ctx.hash;
      rsp_data_in.index      = (ix_ctx.bound < 16'd2) ? 16'd0 : ix_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ix_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(shbi_pkg::LATENCY) rsp_strobe)
      else $error("request transfer without result after pipeline latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, shbi_pkg::LATENCY))
      else $error("result strobe without matching request transfer");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (ix_vld && (ix_ctx.bound > 16'd1)) |-> (ix_rem < ix_ctx.bound))
      else $error("remainder not below bound");
`endif

endmodule

`default_nettype wire

// File: verif/seeded_hash_bounded_index_tb.sv
`default_nettype none

module seeded_hash_bounded_index_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Keeps the seed in use and the queue of predicted hash/index pairs
   class hash_scoreboard;
      logic [31:0]       seed_reg;
      shbi_pkg::rsp_type expected_q[$];
      int unsigned       errors;

      function new();
         seed_reg = '0;
         errors   = 0;
      endfunction

      // Add the golden constant, then the fmix32 finalizer
      static function logic [31:0] mix_round(logic [31:0] v);
         logic [31:0] x;
         x = v + shbi_pkg::GOLDEN;
         x = (x ^ (x >> 16)) * shbi_pkg::MIX_MUL1;
         x = (x ^ (x >> 13)) * shbi_pkg::MIX_MUL2;
         return x ^ (x >> 16);
      endfunction

      // Multiplicative inverse of an odd number modulo 2^32 by Newton steps
      static function logic [31:0] odd_inverse(logic [31:0] a);
         logic [31:0] x;
         x = a;
         repeat (4) x = x * (32'd2 - a * x);
         return x;
      endfunction

      // Undo one mix round
      static function logic [31:0] unmix_round(logic [31:0] v);
         logic [31:0] x;
         x = v ^ (v >> 16);
         x = x * odd_inverse(shbi_pkg::MIX_MUL2);
         x = x ^ (x >> 13) ^ (x >> 26);
         x = x * odd_inverse(shbi_pkg::MIX_MUL1);
         x = x ^ (x >> 16);
         return x - shbi_pkg::GOLDEN;
      endfunction

      // Values at or above this limit fall in the biased tail and get remixed
      static function logic [31:0] reject_limit(logic [15:0] bnd);
         return shbi_pkg::ALL_ONES - (shbi_pkg::ALL_ONES % {16'd0, bnd});
      endfunction

      function logic [31:0] first_mix(logic [7:0] cat);
         return mix_round(seed_reg ^ (shbi_pkg::SALT_BASE * ({24'd0, cat} + 32'd1)));
      endfunction

      // Input id that makes the full hash come out as the wanted value
      function logic [31:0] id_for_hash(logic [7:0] cat, logic [15:0] key, logic [31:0] h);
         return unmix_round(unmix_round(h) ^ {key, key}) ^ first_mix(cat);
      endfunction

      function shbi_pkg::rsp_type predict(shbi_pkg::req_type r);
         shbi_pkg::rsp_type p;
         logic [31:0]       v;
         logic [31:0]       lim;
         v = mix_round(first_mix(r.category) ^ r.input_id);
         p.hash_value = mix_round(v ^ {r.location_key, r.location_key});
         p.index = '0;
         if (r.bound > 16'd1) begin
            lim = reject_limit(r.bound);
            v = p.hash_value;
            for (int n = 1; n <= shbi_pkg::MAX_RETRIES && v >= lim; n++) begin
               v = mix_round(v ^ (shbi_pkg::GOLDEN * 32'(n)));
            end
            p.index = 16'(v % {16'd0, r.bound});
         end
         return p;
      endfunction

      function void note_request(shbi_pkg::req_type r);
         expected_q.push_back(predict(r));
      endfunction

      function void check_result(shbi_pkg::rsp_type got);
         shbi_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual hash %h index %h",
                     $time, got.hash_value, got.index);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.hash_value !== want.hash_value) begin
            $display("%0t hash_value mismatch: expected %h, actual %h",
                     $time, want.hash_value, got.hash_value);
            errors++;
         end
         if (got.index !== want.index) begin
            $display("%0t index mismatch: expected %h, actual %h",
                     $time, want.index, got.index);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   shbi_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   shbi_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [31:0]       csr_wdata = '0;

   hash_scoreboard sb = new();

   seeded_hash_bounded_index dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Observe every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.seed_reg = csr_wdata;
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe) sb.check_result(rsp_data);
      end
   end

   function automatic shbi_pkg::req_type make_req(logic [7:0] cat, logic [31:0] id,
                                                  logic [15:0] key, logic [15:0] bnd);
      shbi_pkg::req_type r;
      r.category     = cat;
      r.input_id     = id;
      r.location_key = key;
      r.bound        = bnd;
      return r;
   endfunction

   // Request whose hash lands on a chosen value
   function automatic shbi_pkg::req_type aimed_req(logic [7:0] cat, logic [15:0] key,
                                                   logic [15:0] bnd, logic [31:0] h);
      return make_req(cat, sb.id_for_hash(cat, key, h), key, bnd);
   endfunction

   function automatic shbi_pkg::req_type random_req();
      shbi_pkg::req_type r;
      logic [31:0]       lim;
      int unsigned       pick;
      r = make_req(8'($urandom), $urandom, 16'($urandom), 16'($urandom));
      if ($urandom_range(99) < 5) r.category = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(99) < 5) r.input_id = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      if ($urandom_range(99) < 5) r.location_key = $urandom_range(1) ? 16'hFFFF : 16'h0;
      pick = $urandom_range(99);
      if (pick < 10) r.bound = 16'($urandom_range(1));
      else if (pick < 25) r.bound = 16'($urandom_range(16, 2));
      else if (pick < 35) r.bound = $urandom_range(3) == 0 ? 16'hFFFF : 16'd1 << $urandom_range(15, 1);
      // Aim some hashes into the biased tail so the retry path gets exercised
      if (r.bound > 16'd1 && $urandom_range(99) < 10) begin
         lim = hash_scoreboard::reject_limit(r.bound);
         r = aimed_req(r.category, r.location_key, r.bound,
                       lim + $urandom_range(shbi_pkg::ALL_ONES - lim, 0));
      end
      return r;
   endfunction

   // Hold the request until it transfers, then idle at random
   task automatic send_req(shbi_pkg::req_type r, int unsigned idle_pct);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop start and wait until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   task automatic write_seed(logic [31:0] value);
      drain();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned idle_pct;
      logic [31:0] seed_list[6];
      seed_list = '{32'hFFFF_FFFF, $urandom, 32'h0, $urandom, 32'h8000_0000, $urandom};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, small and wide bounds, tail hits with reset seed
      send_req(make_req(8'h00, 32'h0000_0000, 16'h0000, 16'd0), 0);
      send_req(make_req(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd1), 0);
      send_req(make_req(8'h00, 32'hFFFF_FFFF, 16'h0000, 16'd2), 0);
      send_req(make_req(8'hFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF), 0);
      send_req(make_req(8'h80, 32'h8000_0000, 16'h8000, 16'h8000), 0);
      send_req(make_req(8'h7F, 32'h7FFF_FFFF, 16'h7FFF, 16'd3), 0);
      send_req(make_req(8'h55, 32'h5555_5555, 16'hAAAA, 16'h7FFF), 0);
      send_req(make_req(8'hAA, 32'hAAAA_AAAA, 16'h5555, 16'd10), 0);
      send_req(aimed_req(8'h01, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF), 0);
      send_req(aimed_req(8'h02, 16'h0000, 16'hFFFF, 32'hFFFF_FFFE), 0);
      send_req(aimed_req(8'h03, 16'hFFFF, 16'h8000, 32'hFFFF_8000), 0);
      send_req(aimed_req(8'h04, 16'hBEEF, 16'h8000, 32'hFFFF_7FFF), 0);
      send_req(aimed_req(8'h05, 16'h0001, 16'd3, 32'hFFFF_FFFF), 0);
      send_req(aimed_req(8'hFE, 16'h00FF, 16'd2, 32'hFFFF_FFFF), 0);
      send_req(aimed_req(8'h10, 16'hFF00, 16'd1, 32'hFFFF_FFFF), 0);
      send_req(aimed_req(8'h20, 16'h4321, 16'd0, 32'hFFFF_FFFF), 0);
      send_req(aimed_req(8'h30, 16'h0F0F, 16'd40000,
                         hash_scoreboard::reject_limit(16'd40000)), 0);
      send_req(aimed_req(8'h40, 16'hF0F0, 16'd40000,
                         hash_scoreboard::reject_limit(16'd40000) - 32'd1), 0);
      send_req(aimed_req(8'hC3, 16'h3C3C, 16'd12345, 32'h0000_0000), 0);
      send_req(aimed_req(8'h3C, 16'hC3C3, 16'd12345, 32'hFFFF_FFFF), 0);

      // Random phases, a new seed for each; sender idling 12%, then 49%, then none
      for (int phase = 0; phase < 6; phase++) begin
         write_seed(seed_list[phase]);
         idle_pct = phase < 2 ? 12 : (phase < 4 ? 49 : 0);
         for (int n = 0; n < 108; n++) begin
            send_req(random_req(), idle_pct);
            if ($urandom_range(99) < 2) drain();
         end
      end

      drain();
      repeat (shbi_pkg::LATENCY + 8) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $display("%0t missing results: expected %0d more, actual 0",
                  $time, sb.expected_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
